[rtl/rsfe_pkg.sv]
// rsfe_pkg: shared types and constants for the rmc sentence field extractor
// no dependencies; used by rsfe_step, rsfe_out and the top level
package rsfe_pkg;

	localparam int unsigned COORD_CHARS = 14;
	localparam int unsigned TIME_CHARS  = 6;
	localparam int unsigned IDX_W       = 4;

	localparam logic [15:0] RECORD_ADDR_RESET = 16'h0004;
	localparam logic [15:0] RECORD_STRIDE     = 16'h0008;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_W      = 8'h57;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HDR_G  = 4'd1,
		PH_HDR_P  = 4'd2,
		PH_HDR_R  = 4'd3,
		PH_HDR_M  = 4'd4,
		PH_HDR_C  = 4'd5,
		PH_TIME   = 4'd6,
		PH_COORD1 = 4'd7,
		PH_COORD2 = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		KIND_TIME   = 3'd0,
		KIND_COORD1 = 3'd1,
		KIND_SIGN1  = 3'd2,
		KIND_COORD2 = 3'd3,
		KIND_SIGN2  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             field_kind;
		logic [7:0]        char_value;
		logic [IDX_W-1:0]  char_position;
		logic              negative;
		logic              overflow;
		logic [7:0]        fix_count;
		logic [15:0]       record_address;
		logic              fix_done;
	} res_t;

endpackage

[rtl/rmc_sentence_field_extractor_top.sv]
// rmc_sentence_field_extractor_top: byte stream in, tagged field requests out
// depends on rsfe_pkg, rsfe_step and rsfe_out
//
// usage: bytes of an nmea stream enter on the s_ group, one per request.
// a "$GPRMC" header starts a sentence; time characters, the two coordinates
// and their signs come out on the m_ group, each tagged with its kind in
// m_tuser. m_tlast marks the second sign, which closes a fix and carries
// the fix count and the record address of that fix.
// a byte is accepted into the input register, the parser step turns it into
// a result, and the result is written to the result register (input register,
// then result register). throughput is one byte per cycle while the receiver
// does not stall, set by the single parser step between the two registers.
// bytes that make no result (header, commas, status letters) pass through
// the same two stages and leave nothing on the output.
// reset clears the parser to await '$', fix count zero, address 4.
// when the receiver stalls, the result register holds and the input
// register fills; s_tready drops once both are occupied.
module rmc_sentence_field_extractor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] char_value, [11:8] char_position,
	                               // [12] negative, [13] overflow,
	                               // [21:14] fix_count, [37:22] record_address
	output logic [2:0]  m_tuser,   // [2:0] field_kind
	output logic        m_tlast    // fix_done
);

	logic           valid_s1;
	logic [7:0]     char_s1;
	logic           out_ready;
	logic           step_en;
	logic           res_valid;
	rsfe_pkg::res_t res;
	rsfe_pkg::res_t res_q;

	assign s_tready = !valid_s1 || out_ready;
	assign step_en  = valid_s1 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	rsfe_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.rx_char   (char_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rsfe_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_en && res_valid),
		.in_res    (res),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {2'b00, res_q.record_address, res_q.fix_count, res_q.overflow,
	                  res_q.negative, res_q.char_position, res_q.char_value};
	assign m_tuser = res_q.field_kind;
	assign m_tlast = res_q.fix_done;

`ifndef ASSERT_OFF
	a_last_is_sign2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == rsfe_pkg::KIND_SIGN2)
		else $error("fix end on a result that is not the second sign");
	a_ovf_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |->
			(m_tuser == rsfe_pkg::KIND_TIME &&
			 m_tdata[11:8] == rsfe_pkg::IDX_W'(rsfe_pkg::TIME_CHARS)) ||
			((m_tuser == rsfe_pkg::KIND_COORD1 || m_tuser == rsfe_pkg::KIND_COORD2) &&
			 m_tdata[11:8] == rsfe_pkg::IDX_W'(rsfe_pkg::COORD_CHARS)))
		else $error("overflow flagged away from field capacity");
	a_neg_on_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |->
			m_tuser == rsfe_pkg::KIND_SIGN1 || m_tuser == rsfe_pkg::KIND_SIGN2)
		else $error("negative flag on a character result");
`endif

endmodule

[rtl/rsfe_step.sv]
// rsfe_step: sentence parser state and one-byte step logic
// depends on rsfe_pkg
module rsfe_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          rx_char,
	output logic                res_valid,
	output rsfe_pkg::res_t      res
);

	rsfe_pkg::phase_t               phase_q, phase_d;
	logic [rsfe_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic                           tcap_q, tcap_d;
	logic [7:0]                     fixes_q, fixes_d;
	logic [15:0]                    addr_q, addr_d;

	logic [rsfe_pkg::IDX_W-1:0]     cap;
	logic                           at_cap;
	logic [rsfe_pkg::IDX_W-1:0]     cap_pos;
	logic [rsfe_pkg::IDX_W-1:0]     cap_next;

	// capacity and saturation of the field index
	always_comb begin
		cap = (phase_q == rsfe_pkg::PH_TIME) ? rsfe_pkg::IDX_W'(rsfe_pkg::TIME_CHARS)
		                                     : rsfe_pkg::IDX_W'(rsfe_pkg::COORD_CHARS);
		at_cap   = (idx_q >= cap);
		cap_pos  = at_cap ? cap : idx_q;
		cap_next = at_cap ? cap : idx_q + rsfe_pkg::IDX_W'(1);
	end

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		tcap_d    = tcap_q;
		fixes_d   = fixes_q;
		addr_d    = addr_q;
		res_valid = 1'b0;
		res.field_kind     = rsfe_pkg::KIND_TIME;
		res.char_value     = rx_char;
		res.char_position  = cap_pos;
		res.negative       = 1'b0;
		res.overflow       = at_cap;
		res.fix_count      = fixes_q;
		res.record_address = addr_q;
		res.fix_done       = 1'b0;
		unique case (phase_q)
			rsfe_pkg::PH_IDLE: begin
				if (rx_char == rsfe_pkg::CH_DOLLAR) begin
					phase_d = rsfe_pkg::PH_HDR_G;
					idx_d   = '0;
					tcap_d  = 1'b1;
				end
			end
			rsfe_pkg::PH_HDR_G: phase_d = (rx_char == rsfe_pkg::CH_G) ? rsfe_pkg::PH_HDR_P
			                                                           : rsfe_pkg::PH_IDLE;
			rsfe_pkg::PH_HDR_P: phase_d = (rx_char == rsfe_pkg::CH_P) ? rsfe_pkg::PH_HDR_R
			                                                           : rsfe_pkg::PH_IDLE;
			rsfe_pkg::PH_HDR_R: phase_d = (rx_char == rsfe_pkg::CH_R) ? rsfe_pkg::PH_HDR_M
			                                                           : rsfe_pkg::PH_IDLE;
			rsfe_pkg::PH_HDR_M: phase_d = (rx_char == rsfe_pkg::CH_M) ? rsfe_pkg::PH_HDR_C
			                                                           : rsfe_pkg::PH_IDLE;
			rsfe_pkg::PH_HDR_C: phase_d = (rx_char == rsfe_pkg::CH_C) ? rsfe_pkg::PH_TIME
			                                                           : rsfe_pkg::PH_IDLE;
			rsfe_pkg::PH_TIME: begin
				priority if (rx_char == rsfe_pkg::CH_V) begin
					phase_d = rsfe_pkg::PH_IDLE;
					idx_d   = '0;
				end else if (rx_char == rsfe_pkg::CH_A) begin
					phase_d = rsfe_pkg::PH_COORD1;
					idx_d   = '0;
					tcap_d  = 1'b1;
				end else if (rx_char == rsfe_pkg::CH_COMMA || !tcap_q) begin
					phase_d = phase_q;
				end else if (rx_char == rsfe_pkg::CH_POINT) begin
					tcap_d = 1'b0;
				end else begin
					idx_d     = cap_next;
					res_valid = 1'b1;
				end
			end
			rsfe_pkg::PH_COORD1: begin
				priority if (rx_char == rsfe_pkg::CH_N || rx_char == rsfe_pkg::CH_S) begin
					phase_d   = rsfe_pkg::PH_COORD2;
					idx_d     = '0;
					res_valid = 1'b1;
					res.field_kind    = rsfe_pkg::KIND_SIGN1;
					res.char_value    = '0;
					res.char_position = '0;
					res.overflow      = 1'b0;
					res.negative      = (rx_char == rsfe_pkg::CH_S);
				end else if (rx_char == rsfe_pkg::CH_COMMA) begin
					phase_d = phase_q;
				end else begin
					idx_d     = cap_next;
					res_valid = 1'b1;
					res.field_kind = rsfe_pkg::KIND_COORD1;
				end
			end
			rsfe_pkg::PH_COORD2: begin
				priority if (rx_char == rsfe_pkg::CH_E || rx_char == rsfe_pkg::CH_W) begin
					phase_d   = rsfe_pkg::PH_IDLE;
					idx_d     = '0;
					fixes_d   = fixes_q + 8'd1;
					addr_d    = addr_q + rsfe_pkg::RECORD_STRIDE;
					res_valid = 1'b1;
					res.field_kind    = rsfe_pkg::KIND_SIGN2;
					res.char_value    = '0;
					res.char_position = '0;
					res.overflow      = 1'b0;
					res.negative      = (rx_char == rsfe_pkg::CH_W);
					res.fix_count     = fixes_d;
					res.fix_done      = 1'b1;
				end else if (rx_char == rsfe_pkg::CH_COMMA) begin
					phase_d = phase_q;
				end else begin
					idx_d     = cap_next;
					res_valid = 1'b1;
					res.field_kind = rsfe_pkg::KIND_COORD2;
				end
			end
			default: phase_d = rsfe_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rsfe_pkg::PH_IDLE;
			idx_q   <= '0;
			tcap_q  <= 1'b1;
			fixes_q <= '0;
			addr_q  <= rsfe_pkg::RECORD_ADDR_RESET;
		end else if (step_en) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			tcap_q  <= tcap_d;
			fixes_q <= fixes_d;
			addr_q  <= addr_d;
		end
	end

`ifndef ASSERT_OFF
	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= rsfe_pkg::IDX_W'(rsfe_pkg::COORD_CHARS))
		else $error("field index past coordinate capacity");
	a_fix_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && res.fix_done |=> addr_q == $past(addr_q) + rsfe_pkg::RECORD_STRIDE)
		else $error("record address did not advance after fix");
	a_time_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rsfe_pkg::PH_TIME |-> idx_q <= rsfe_pkg::IDX_W'(rsfe_pkg::TIME_CHARS))
		else $error("time index past time capacity");
`endif

endmodule

[rtl/rsfe_out.sv]
// rsfe_out: result register with stream handshake toward the receiver
// depends on rsfe_pkg
module rsfe_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  rsfe_pkg::res_t  in_res,
	output logic            out_ready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output rsfe_pkg::res_t  res_q
);

	logic valid_q;

	assign out_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule
